// ===== rtl/core/rwac_pkg.sv =====
// Shared types, codes and constants for the range-wrapping arithmetic counter.
package rwac_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int OPERAND_W       = 16;
    localparam int SPAN_W          = 16;
    localparam int MODE_W          = 3;
    localparam int ERR_W           = 2;
    localparam int CFG_INDEX_W     = 1;

    localparam logic signed [FIELD_W-1:0] RANGE_LOW_RESET  = 16'sd0;
    localparam logic signed [FIELD_W-1:0] RANGE_HIGH_RESET = 16'sd16;

    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LOW  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_HIGH = 1'd1;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ASSIGN = 3'd0,
        MODE_INC    = 3'd1,
        MODE_DEC    = 3'd2,
        MODE_ADD    = 3'd3,
        MODE_SUB    = 3'd4,
        MODE_MUL    = 3'd5,
        MODE_DIV    = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_QUOT_WAIT,
        ST_RAW,
        ST_DIFF,
        ST_REM_START,
        ST_REM_WAIT,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic keep;
        logic start_quot;
        logic latch_raw;
        logic latch_diff;
        logic start_rem;
        logic latch_fix;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic keep;
        logic is_div;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/rwac_div.sv =====
// Iterative restoring divider: one quotient bit per cycle, unsigned operands.
module rwac_div #(
    parameter int DIVIDEND_W = rwac_pkg::VALUE_WIDTH_DEF + 17
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [DIVIDEND_W-1:0]         dividend,
    input  logic [rwac_pkg::SPAN_W-1:0]   divisor,
    output logic                          done,
    output logic [DIVIDEND_W-1:0]         quotient,
    output logic [rwac_pkg::SPAN_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [DIVIDEND_W-1:0]         quo_reg;
    logic [rwac_pkg::SPAN_W-1:0]   rem_reg;
    logic [rwac_pkg::SPAN_W-1:0]   div_reg;

    logic [rwac_pkg::SPAN_W:0]     trial;
    logic                          fits;
    logic [rwac_pkg::SPAN_W:0]     trial_sub;

    assign trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits      = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? trial_sub[rwac_pkg::SPAN_W-1:0] : trial[rwac_pkg::SPAN_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/rwac_dpath.sv =====
// Datapath: range registers, stored value, operation unit, range folding and result register.
module rwac_dpath #(
    parameter int VALUE_WIDTH = rwac_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [rwac_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rwac_pkg::FIELD_W-1:0]         cfg_data,
    input  logic [rwac_pkg::MODE_W-1:0]          in_mode,
    input  logic signed [rwac_pkg::OPERAND_W-1:0] in_operand,
    input  logic                                 out_ready,
    input  rwac_pkg::cmd_t                       cmd,
    output rwac_pkg::status_t                    status,
    output logic                                 out_valid,
    output logic [rwac_pkg::FIELD_W-1:0]         out_new_value,
    output logic [rwac_pkg::FIELD_W-1:0]         out_old_value,
    output logic [rwac_pkg::ERR_W-1:0]           out_error
);

    // Wide enough for a product plus the lower bound, with a sign bit to spare.
    localparam int RAW_W = VALUE_WIDTH + 17;

    logic signed [rwac_pkg::FIELD_W-1:0]   lo_reg;
    logic signed [rwac_pkg::FIELD_W-1:0]   hi_reg;
    logic signed [VALUE_WIDTH-1:0]         cur_reg;
    logic                                  out_valid_reg;

    logic [rwac_pkg::MODE_W-1:0]           mode_reg;
    logic signed [rwac_pkg::OPERAND_W-1:0] opnd_reg;
    logic signed [VALUE_WIDTH-1:0]         old_reg;
    logic [rwac_pkg::ERR_W-1:0]            err_reg;
    logic                                  keep_reg;
    logic signed [RAW_W-1:0]               raw_reg;
    logic signed [RAW_W-1:0]               d_reg;
    logic signed [VALUE_WIDTH-1:0]         new_reg;
    logic [rwac_pkg::FIELD_W-1:0]          res_new_reg;
    logic [rwac_pkg::FIELD_W-1:0]          res_old_reg;
    logic [rwac_pkg::ERR_W-1:0]            res_err_reg;

    logic signed [rwac_pkg::SPAN_W:0]      span_s;
    logic                                  in_empty;
    logic                                  in_div;
    logic                                  in_divz;
    logic                                  in_known;
    logic [rwac_pkg::ERR_W-1:0]            in_err;

    logic signed [RAW_W-1:0]               old_w;
    logic signed [RAW_W-1:0]               opnd_w;
    logic signed [RAW_W-1:0]               old_mag;
    logic signed [rwac_pkg::SPAN_W:0]      opnd_mag;
    logic signed [RAW_W-1:0]               d_mag;
    logic                                  div_start;
    logic [RAW_W-1:0]                      div_dividend;
    logic [rwac_pkg::SPAN_W-1:0]           div_divisor;
    logic                                  div_done;
    logic [RAW_W-1:0]                      div_quot;
    logic [rwac_pkg::SPAN_W-1:0]           div_rem;

    logic signed [RAW_W-1:0]               quot_s;
    logic signed [VALUE_WIDTH+15:0]        prod;
    logic signed [RAW_W-1:0]               raw_next;
    logic signed [rwac_pkg::SPAN_W:0]      rem_s;
    logic signed [rwac_pkg::SPAN_W:0]      fold_r;
    logic signed [rwac_pkg::SPAN_W:0]      fold_sum;
    logic signed [RAW_W-1:0]               fold_w;
    logic signed [31:0]                    new_ext;
    logic signed [31:0]                    old_ext;
    logic                                  out_free;

    assign span_s   = 17'(hi_reg) - 17'(lo_reg);
    assign in_empty = hi_reg <= lo_reg;
    assign in_div   = in_mode == rwac_pkg::MODE_DIV;
    assign in_divz  = in_div && (in_operand == '0);
    assign in_known = in_mode <= rwac_pkg::MODE_DIV;
    assign in_err   = in_empty ? rwac_pkg::ERR_EMPTY :
                      in_divz  ? rwac_pkg::ERR_DIV_ZERO : rwac_pkg::ERR_OK;

    assign old_w    = RAW_W'(old_reg);
    assign opnd_w   = RAW_W'(opnd_reg);
    assign old_mag  = old_w[RAW_W-1] ? -old_w : old_w;
    assign opnd_mag = opnd_reg[rwac_pkg::OPERAND_W-1] ? -17'(opnd_reg) : 17'(opnd_reg);
    assign d_mag    = d_reg[RAW_W-1] ? -d_reg : d_reg;

    // The divider is shared between the quotient of a divide and the fold remainder.
    assign div_start    = cmd.start_quot | cmd.start_rem;
    assign div_dividend = cmd.start_rem ? d_mag : old_mag;
    assign div_divisor  = cmd.start_rem ? span_s[rwac_pkg::SPAN_W-1:0]
                                        : opnd_mag[rwac_pkg::SPAN_W-1:0];

    rwac_div #(
        .DIVIDEND_W (RAW_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign quot_s = (old_reg[VALUE_WIDTH-1] ^ opnd_reg[rwac_pkg::OPERAND_W-1])
                    ? -$signed(div_quot) : $signed(div_quot);
    assign prod   = old_reg * opnd_reg;

    always_comb
    begin
        case (mode_reg)
            rwac_pkg::MODE_ASSIGN: raw_next = opnd_w;
            rwac_pkg::MODE_INC:    raw_next = old_w + RAW_W'(1);
            rwac_pkg::MODE_DEC:    raw_next = old_w - RAW_W'(1);
            rwac_pkg::MODE_ADD:    raw_next = old_w + opnd_w;
            rwac_pkg::MODE_SUB:    raw_next = old_w - opnd_w;
            rwac_pkg::MODE_MUL:    raw_next = RAW_W'(prod);
            rwac_pkg::MODE_DIV:    raw_next = quot_s;
            default:               raw_next = old_w;
        endcase
    end

    // Floored remainder: a nonzero remainder of a negative offset counts down from the span.
    assign rem_s    = {1'b0, div_rem};
    assign fold_r   = (d_reg[RAW_W-1] && (div_rem != '0)) ? span_s - rem_s : rem_s;
    assign fold_sum = 17'(lo_reg) + fold_r;
    assign fold_w   = RAW_W'(fold_sum);

    assign new_ext  = 32'(new_reg);
    assign old_ext  = 32'(old_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg        <= rwac_pkg::RANGE_LOW_RESET;
            hi_reg        <= rwac_pkg::RANGE_HIGH_RESET;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == rwac_pkg::REG_RANGE_LOW))
            begin
                lo_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == rwac_pkg::REG_RANGE_HIGH))
            begin
                hi_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                cur_reg       <= new_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            opnd_reg <= in_operand;
            old_reg  <= cur_reg;
            err_reg  <= in_err;
            keep_reg <= in_empty || in_divz || !in_known;
        end
        if (cmd.latch_raw)
        begin
            raw_reg <= raw_next;
        end
        if (cmd.latch_diff)
        begin
            d_reg <= raw_reg - RAW_W'(lo_reg);
        end
        if (cmd.keep)
        begin
            new_reg <= old_reg;
        end
        else if (cmd.latch_fix)
        begin
            new_reg <= fold_w[VALUE_WIDTH-1:0];
        end
        if (cmd.commit)
        begin
            res_new_reg <= new_ext[rwac_pkg::FIELD_W-1:0];
            res_old_reg <= old_ext[rwac_pkg::FIELD_W-1:0];
            res_err_reg <= err_reg;
        end
    end

    assign status.keep     = keep_reg;
    assign status.is_div   = mode_reg == rwac_pkg::MODE_DIV;
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign out_valid     = out_valid_reg;
    assign out_new_value = res_new_reg;
    assign out_old_value = res_old_reg;
    assign out_error     = res_err_reg;

endmodule

// ===== rtl/core/rwac_ctrl.sv =====
// Controller: sequences one transaction through operation, division and folding.
module rwac_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rwac_pkg::status_t   status,
    output rwac_pkg::cmd_t      cmd
);

    rwac_pkg::state_t state_reg;
    rwac_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwac_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            rwac_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rwac_pkg::ST_PREP;
                end
            end
            rwac_pkg::ST_PREP:
            begin
                if (status.keep)
                begin
                    cmd.keep   = 1'b1;
                    state_next = rwac_pkg::ST_DONE;
                end
                else if (status.is_div)
                begin
                    cmd.start_quot = 1'b1;
                    state_next     = rwac_pkg::ST_QUOT_WAIT;
                end
                else
                begin
                    state_next = rwac_pkg::ST_RAW;
                end
            end
            rwac_pkg::ST_QUOT_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = rwac_pkg::ST_RAW;
                end
            end
            rwac_pkg::ST_RAW:
            begin
                cmd.latch_raw = 1'b1;
                state_next    = rwac_pkg::ST_DIFF;
            end
            rwac_pkg::ST_DIFF:
            begin
                cmd.latch_diff = 1'b1;
                state_next     = rwac_pkg::ST_REM_START;
            end
            rwac_pkg::ST_REM_START:
            begin
                cmd.start_rem = 1'b1;
                state_next    = rwac_pkg::ST_REM_WAIT;
            end
            rwac_pkg::ST_REM_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = rwac_pkg::ST_FIX;
                end
            end
            rwac_pkg::ST_FIX:
            begin
                cmd.latch_fix = 1'b1;
                state_next    = rwac_pkg::ST_DONE;
            end
            rwac_pkg::ST_DONE:
            begin
                // Hold here until the result register can take the new result.
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = rwac_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rwac_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/range_wrapping_arithmetic_counter_unit.sv =====
// Top level of the range-wrapping arithmetic counter.
//
// Usage: a counter value kept inside [range_low, range_high), set through the cfg
// channel (index 0 is range_low, index 1 is range_high, written only while idle, a
// rule on the user that the block does not enforce). Each input transaction on s_*
// carries an operation in s_tuser and an operand in s_tdata; it returns one output
// transaction on m_* with the new value, the old value and an error code. An empty
// range, a divide by zero or an unused mode keeps the value. One transaction is
// processed at a time. The shared divider runs VALUE_WIDTH+17 iterations per pass:
// the fold remainder needs one pass, a divide needs two. The next input is accepted
// in the cycle after the result is written, also while m_tready is low; a finished
// result waits in the controller when the output register is still full. Reset
// clears the value to 0, the range to [0, 16) and drops any result.
module range_wrapping_arithmetic_counter_unit #(
    parameter int VALUE_WIDTH = rwac_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // [15:0] operand
    input  logic [2:0]                          s_tuser,   // [2:0] mode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,   // [15:0] new_value, [31:16] old_value
    output logic [1:0]                          m_tuser,   // [1:0] error
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rwac_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [15:0]                         cfg_data
);

    rwac_pkg::cmd_t                 cmd;
    rwac_pkg::status_t              status;
    logic [rwac_pkg::FIELD_W-1:0]   new_value;
    logic [rwac_pkg::FIELD_W-1:0]   old_value;
    logic [rwac_pkg::ERR_W-1:0]     error;

    assign cfg_ready = 1'b1;

    rwac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rwac_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_mode       (s_tuser),
        .in_operand    (s_tdata),
        .out_ready     (m_tready),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (m_tvalid),
        .out_new_value (new_value),
        .out_old_value (old_value),
        .out_error     (error)
    );

    assign m_tdata = {old_value, new_value};
    assign m_tuser = error;

    // Only one transaction is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a transaction is in progress");

    // A result with an error reports the same new and old value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rwac_pkg::ERR_OK) |-> m_tdata[15:0] == m_tdata[31:16])
        else $error("error result changed the value");

    // Only the defined error codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == rwac_pkg::ERR_OK || m_tuser == rwac_pkg::ERR_DIV_ZERO
                     || m_tuser == rwac_pkg::ERR_EMPTY)
        else $error("undefined error code");

    // A result is only committed from the controller when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !m_tvalid || m_tready)
        else $error("result register overwritten");

endmodule

// ===== dv/tb_range_wrapping_arithmetic_counter_unit.sv =====
// Testbench for the range-wrapping arithmetic counter, checked against a predictor.
module tb_range_wrapping_arithmetic_counter_unit;

    import rwac_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
    localparam int IDLE_PCT   = 28;
    localparam int HOLD_LEN   = 600;
    localparam int HOLD_EVERY = 900;
    localparam int SETTLE     = 8;
    localparam int TAIL       = 100;
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic signed [15:0] operand;
    } counter_op_t;

    typedef struct {
        logic signed [15:0] new_value;
        logic signed [15:0] old_value;
        logic [ERR_W-1:0]   error;
    } counter_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata = '0;
    logic [2:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic [1:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]            cfg_data = '0;

    // Predictor state: the value the counter should hold and its current range.
    logic signed [15:0] counter_value = 16'sd0;
    logic signed [15:0] range_low = RANGE_LOW_RESET;
    logic signed [15:0] range_high = RANGE_HIGH_RESET;

    counter_op_t     pending_ops[$];
    counter_result_t expected_results[$];

    int  ops_queued = 0;
    int  fail_count = 0;
    bit  steady = 1'b0;
    int  hold_left = 0;
    int  hold_accepts = 0;
    int  next_hold = 400;

    range_wrapping_arithmetic_counter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic counter_result_t predict_counter(input logic [MODE_W-1:0] mode,
                                                        input logic signed [15:0] operand);
        counter_result_t res;
        longint oldv;
        longint opnd;
        longint raw;
        longint span;
        longint rem;
        bit     apply;
        oldv = counter_value;
        opnd = operand;
        raw = oldv;
        apply = 1'b1;
        res.old_value = counter_value;
        res.new_value = counter_value;
        res.error = ERR_OK;
        // An empty range wins over every other check, the divide by zero included.
        if (range_high <= range_low)
        begin
            res.error = ERR_EMPTY;
            apply = 1'b0;
        end
        else
        begin
            case (mode)
                MODE_ASSIGN: raw = opnd;
                MODE_INC:    raw = oldv + 1;
                MODE_DEC:    raw = oldv - 1;
                MODE_ADD:    raw = oldv + opnd;
                MODE_SUB:    raw = oldv - opnd;
                MODE_MUL:    raw = oldv * opnd;
                MODE_DIV:
                begin
                    if (opnd == 0)
                    begin
                        res.error = ERR_DIV_ZERO;
                        apply = 1'b0;
                    end
                    else
                    begin
                        raw = oldv / opnd;
                    end
                end
                default:     apply = 1'b0;
            endcase
        end
        if (apply)
        begin
            span = longint'(range_high) - longint'(range_low);
            rem = (raw - longint'(range_low)) % span;
            if (rem < 0)
                rem += span;
            res.new_value = 16'(longint'(range_low) + rem);
        end
        return res;
    endfunction

    // Input driver: offers queued operations and records the expected result on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        counter_result_t predicted;
        counter_op_t     next_op;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = predict_counter(s_tuser, s_tdata);
                counter_value = predicted.new_value;
                expected_results.push_back(predicted);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_op.operand;
                    s_tuser  <= next_op.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Periodic long back-pressure on the result side, so the block fills up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left    <= 0;
            hold_accepts <= 0;
            next_hold    <= 400;
        end
        else
        begin
            if (s_tvalid && s_tready)
                hold_accepts <= hold_accepts + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (hold_accepts >= next_hold)
            begin
                hold_left <= HOLD_LEN;
                next_hold <= next_hold + HOLD_EVERY;
            end
        end
    end

    // Result monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        counter_result_t want;
        logic signed [15:0] got_new;
        logic signed [15:0] got_old;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_new = m_tdata[15:0];
                got_old = m_tdata[31:16];
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT)
                        $display("unexpected result: new %0d old %0d error %0d",
                                 got_new, got_old, m_tuser);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got_new !== want.new_value || got_old !== want.old_value
                        || m_tuser !== want.error)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORT)
                            $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.new_value, want.old_value, want.error,
                                     got_new, got_old, m_tuser);
                    end
                end
            end
            m_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic add_op(input logic [MODE_W-1:0] mode, input int operand);
        counter_op_t op;
        op.mode = mode;
        op.operand = 16'(operand);
        pending_ops.push_back(op);
        ops_queued++;
    endtask

    // Waits until every queued operation has been sent and answered; sampled away from
    // the active edge so the driver's updates of that edge are already visible.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= 16'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_RANGE_LOW)
            range_low = 16'(value);
        else
            range_high = 16'(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_range(input int lo, input int hi);
        write_reg(REG_RANGE_LOW, lo);
        write_reg(REG_RANGE_HIGH, hi);
        @(negedge clk);
    endtask

    initial
    begin
        int                phase;
        int                lo;
        int                hi;
        int                count;
        int                pick;
        logic [MODE_W-1:0] mode;
        int                operand;
        int                extremes[5];
        extremes = '{-32768, 32767, 0, 1, -1};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default range [0, 16): wraps both ways, extremes of the operand, every operation.
        add_op(MODE_ASSIGN, 5);
        add_op(MODE_INC, 0);
        add_op(MODE_DEC, -1);
        add_op(MODE_ASSIGN, 0);
        add_op(MODE_DEC, 0);
        add_op(MODE_INC, 12345);
        add_op(MODE_ASSIGN, 32767);
        add_op(MODE_ASSIGN, -32768);
        add_op(MODE_ADD, 32767);
        add_op(MODE_SUB, -32768);
        add_op(MODE_SUB, 32767);
        add_op(MODE_MUL, -32768);
        add_op(MODE_ASSIGN, 7);
        add_op(MODE_MUL, 32767);
        add_op(MODE_DIV, 0);
        add_op(MODE_DIV, 3);
        add_op(MODE_ASSIGN, -1);
        add_op(MODE_DIV, -4);
        add_op(MODE_DIV, -1);
        add_op(MODE_DIV, -32768);
        add_op(MODE_UNUSED, 99);
        wait_idle();

        // Widest range; the stored value is not refolded until the next operation.
        set_range(-32768, 32767);
        add_op(MODE_INC, 0);
        add_op(MODE_ASSIGN, -32768);
        add_op(MODE_DEC, 0);
        add_op(MODE_ASSIGN, -32768);
        add_op(MODE_DIV, -1);
        add_op(MODE_MUL, -32768);
        add_op(MODE_ADD, -32768);
        wait_idle();

        // Empty ranges, equal bounds and inverted bounds; the empty check comes first.
        set_range(5, 5);
        add_op(MODE_DIV, 0);
        add_op(MODE_INC, 0);
        add_op(MODE_UNUSED, 0);
        wait_idle();
        set_range(10, -10);
        add_op(MODE_ASSIGN, 3);
        add_op(MODE_MUL, 2);
        wait_idle();

        // Span of one at the top of the field.
        set_range(32766, 32767);
        add_op(MODE_ASSIGN, 0);
        add_op(MODE_SUB, 1);
        wait_idle();

        phase = 0;
        while (ops_queued < 2000)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
            begin
                lo = -32768;
                hi = 32767;
            end
            else if (pick == 1)
            begin
                lo = $urandom_range(65534) - 32768;
                hi = lo + 1;
            end
            else if (pick == 2)
            begin
                hi = $urandom_range(65535) - 32768;
                lo = hi + $urandom_range(32767 - hi);
            end
            else if (pick <= 6)
            begin
                lo = $urandom_range(200) - 100;
                hi = lo + $urandom_range(1, 50);
            end
            else
            begin
                lo = $urandom_range(65535) - 32768;
                hi = $urandom_range(65535) - 32768;
                if (lo == hi)
                    hi = lo + 1;
                if (hi < lo)
                begin
                    hi = hi ^ lo;
                    lo = hi ^ lo;
                    hi = hi ^ lo;
                end
            end
            set_range(lo, hi);
            steady = (phase == 3);
            count = (pick == 2) ? 20 : $urandom_range(100, 300);
            repeat (count)
            begin
                if ($urandom_range(99) < 3)
                    mode = MODE_UNUSED;
                else
                    mode = MODE_W'($urandom_range(MODE_DIV));
                pick = $urandom_range(9);
                if (pick <= 3)
                    operand = $urandom_range(40) - 20;
                else if (pick == 4)
                    operand = extremes[$urandom_range(4)];
                else if (pick == 5 && hi > lo)
                    operand = lo + $urandom_range(hi - lo - 1);
                else
                    operand = $urandom_range(65535) - 32768;
                add_op(mode, operand);
            end
            wait_idle();
            phase++;
        end

        steady = 1'b0;
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
